// ===== design/fcsg_pkg.sv =====
package fcsg_pkg;

  // Radius is a 5-bit field, so the half-width fits 5 bits and r*r fits 10.
  localparam int unsigned RootW = 5;
  localparam int unsigned SqW   = 2 * RootW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ROOT = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  typedef struct packed {
    logic             done;
    logic [RootW-1:0] root;
  } root_rsp_t;

endpackage

// ===== design/fcsg_isqrt.sv =====
module fcsg_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [fcsg_pkg::SqW-1:0]      val_i,
  output fcsg_pkg::root_rsp_t           rsp_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [fcsg_pkg::RootW-1:0]    bit_q;
  logic [fcsg_pkg::RootW-1:0]    root_q;
  logic [fcsg_pkg::SqW-1:0]      val_q;
  logic [fcsg_pkg::RootW-1:0]    trial;
  logic [fcsg_pkg::SqW-1:0]      trial_sq;
  logic                          fit;

  // one result bit per cycle, MSB first: keep the bit if trial^2 <= value
  assign trial    = root_q | bit_q;
  assign trial_sq = fcsg_pkg::SqW'(trial) * fcsg_pkg::SqW'(trial);
  assign fit      = trial_sq <= val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      bit_q  <= {1'b1, {(fcsg_pkg::RootW-1){1'b0}}};
    end else if (busy_q) begin
      bit_q <= bit_q >> 1;
      if (bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      root_q <= '0;
      val_q  <= val_i;
    end else if (busy_q && fit) begin
      root_q <= trial;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

// ===== design/filled_circle_span_generator.sv =====
// Filled circle span generator: one request (center, radius, color) on the
// slave stream yields 2r+1 horizontal spans on the master stream, rows from
// center_y-r to center_y+r in rising order, tlast on the final one; a zero
// radius yields nothing and a radius above MAX_RADIUS is clipped to it. Each
// span's half-width is an exact floor square root, taken one bit per cycle on
// a single 5x5 multiply-compare unit; the radicand is updated by one add per
// row. The next span's root is started only after the current span has
// transferred, so output stalls delay the circle. The block takes a new
// request only when the previous circle's last span has transferred.
module filled_circle_span_generator #(
  parameter int unsigned MAX_RADIUS = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // center_x[15:0], center_y[31:16], circle_radius[36:32], fill_color[68:37]
  input  logic [71:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // span_left[16:0], span_right[33:17], span_row[50:34], span_color[82:51]
  output logic [87:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  localparam logic [fcsg_pkg::RootW-1:0] RMax = fcsg_pkg::RootW'(MAX_RADIUS);

  fcsg_pkg::state_e                state_q, state_d;
  fcsg_pkg::root_rsp_t             rsp;

  logic [15:0]                     cx_q, cy_q;
  logic [31:0]                     color_q;
  logic [fcsg_pkg::RootW-1:0]      r_q;
  logic signed [fcsg_pkg::RootW:0] dy_q;
  logic [fcsg_pkg::SqW-1:0]        v_q;
  logic                            start_q;

  logic [16:0]                     left_q, right_q, row_q;
  logic [31:0]                     ocolor_q;
  logic                            last_q;
  logic                            ovalid_q;

  logic [fcsg_pkg::RootW-1:0]      in_r_raw, in_r;
  logic                            in_acc, out_acc, load_req, step;
  logic signed [fcsg_pkg::SqW+1:0] v_next;

  assign in_r_raw = s_axis_tdata_i[36:32];
  assign in_r     = (in_r_raw > RMax) ? RMax : in_r_raw;

  assign s_axis_tready_o = (state_q == fcsg_pkg::ST_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc  = ovalid_q && m_axis_tready_i;
  assign load_req = in_acc && (in_r != '0);
  assign step     = out_acc && !last_q;

  // r^2 - (dy+1)^2 = (r^2 - dy^2) - 2dy - 1
  assign v_next = $signed({2'b00, v_q})
                - ($signed({{(fcsg_pkg::SqW-fcsg_pkg::RootW){dy_q[fcsg_pkg::RootW]}}, dy_q}) <<< 1)
                - 12'sd1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      fcsg_pkg::ST_IDLE: if (load_req) state_d = fcsg_pkg::ST_ROOT;
      fcsg_pkg::ST_ROOT: if (rsp.done) state_d = fcsg_pkg::ST_EMIT;
      fcsg_pkg::ST_EMIT: begin
        if (out_acc) state_d = last_q ? fcsg_pkg::ST_IDLE : fcsg_pkg::ST_ROOT;
      end
      default: state_d = fcsg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fcsg_pkg::ST_IDLE;
      start_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= load_req || step;
      if (rsp.done) begin
        ovalid_q <= 1'b1;
      end else if (out_acc) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_req) begin
      cx_q    <= s_axis_tdata_i[15:0];
      cy_q    <= s_axis_tdata_i[31:16];
      color_q <= s_axis_tdata_i[68:37];
      r_q     <= in_r;
      dy_q    <= -$signed({1'b0, in_r});
      v_q     <= '0;
    end else if (step) begin
      dy_q <= dy_q + 6'sd1;
      v_q  <= v_next[fcsg_pkg::SqW-1:0];
    end
    if (rsp.done) begin
      left_q   <= {cx_q[15], cx_q} - {{(17-fcsg_pkg::RootW){1'b0}}, rsp.root};
      right_q  <= {cx_q[15], cx_q} + {{(17-fcsg_pkg::RootW){1'b0}}, rsp.root};
      row_q    <= {cy_q[15], cy_q}
                + {{(16-fcsg_pkg::RootW){dy_q[fcsg_pkg::RootW]}}, dy_q};
      ocolor_q <= color_q;
      last_q   <= (dy_q == $signed({1'b0, r_q}));
    end
  end

  fcsg_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_q),
    .val_i  (v_q),
    .rsp_o  (rsp)
  );

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {5'b0, ocolor_q, row_q, right_q, left_q};
  assign m_axis_tlast_o  = last_q;

`ifndef SYNTH
  a_valid_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> state_q == fcsg_pkg::ST_EMIT)
    else $error("output valid outside emit state");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_q) |=> s_axis_tready_o)
    else $error("circle did not end after last span");

  a_dy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != fcsg_pkg::ST_IDLE |-> dy_q <= $signed({1'b0, r_q}))
    else $error("row offset past radius");

  a_root_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> state_q == fcsg_pkg::ST_ROOT)
    else $error("root result outside root state");
`endif

endmodule
